// ===== design/ivk_pkg.sv =====
// ---------------------------------------------------------------------------
// ivk_pkg
// Shared widths, constants, types and tables for the SCARA inverse velocity
// kinematics pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package ivk_pkg;

    localparam int CORDIC_STAGES = 16;   // 8 .. 24
    localparam int DIV_STEPS     = 32;

    localparam int XW = 34;              // CORDIC x/y
    localparam int ZW = 33;              // CORDIC residual angle
    localparam int JW = 24;              // Jacobian terms, Q.20
    localparam int NW = 61;              // numerator * 2^20 magnitude
    localparam int DW = 49;              // determinant magnitude

    localparam logic signed [17:0] ANG_PI      = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [0:0] REG_LINK_ONE = 1'b0;
    localparam logic [0:0] REG_LINK_TWO = 1'b1;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic               neg_one;
        logic               neg_sum;
    } t_side;

    typedef struct packed {
        logic [NW-1:0]      rem_one;
        logic [NW-1:0]      rem_two;
        logic [31:0]        quo_one;
        logic [31:0]        quo_two;
        logic [DW-1:0]      den;
        logic               neg_one;
        logic               neg_two;
        logic               ovf_one;
        logic               ovf_two;
        logic               sing;
        logic signed [15:0] r3;
    } t_div;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_red;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [30:0] atan_val(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // bring a 17 bit angle into +-pi/2, note if sin/cos flip sign
    function automatic t_red reduce(input logic signed [16:0] a);
        logic signed [17:0] t;
        t_red r;
        t = 18'(a);
        if (t > ANG_PI) begin
            t = t - ANG_TWO_PI;
        end else if (t < -ANG_PI) begin
            t = t + ANG_TWO_PI;
        end
        r.neg = 1'b0;
        if (t > ANG_HALF_PI) begin
            t = t - ANG_PI;
            r.neg = 1'b1;
        end else if (t < -ANG_HALF_PI) begin
            t = t + ANG_PI;
            r.neg = 1'b1;
        end
        r.z = {t[15:0], 17'b0};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ivk_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// ivk_cordic_cell
// One CORDIC rotation step for two angles, plus side payload, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ivk_cordic_cell import ivk_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [4:0] i_stage,
    input  wire logic       i_valid,
    input  wire t_rot       i_rot_a,
    input  wire t_rot       i_rot_b,
    input  wire t_side      i_side,
    output logic            o_valid,
    output t_rot            o_rot_a,
    output t_rot            o_rot_b,
    output t_side           o_side
);

    function automatic t_rot rotate(input t_rot r, input logic [4:0] s);
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        t_rot o;
        dx = r.y >>> s;
        dy = r.x >>> s;
        at = $signed({2'b00, atan_val(s)});
        if (!r.z[ZW-1]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - at;
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + at;
        end
        return o;
    endfunction

    logic  r_valid;
    t_rot  r_rot_a, r_rot_b;
    t_side r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot_a <= rotate(i_rot_a, i_stage);
            r_rot_b <= rotate(i_rot_b, i_stage);
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot_a = r_rot_a;
    assign o_rot_b = r_rot_b;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== design/ivk_div_cell.sv =====
// ---------------------------------------------------------------------------
// ivk_div_cell
// One restoring-division quotient bit for both rates, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ivk_div_cell import ivk_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [4:0] i_bit,
    input  wire logic       i_valid,
    input  wire t_div       i_div,
    output logic            o_valid,
    output t_div            o_div
);

    logic       r_valid;
    t_div       r_div;
    t_div       n_div;
    logic [NW+31:0] dsh;

    always_comb begin
        n_div = i_div;
        dsh   = {{(NW+32-DW){1'b0}}, i_div.den} << i_bit;
        if ({32'b0, i_div.rem_one} >= dsh) begin
            n_div.rem_one = i_div.rem_one - dsh[NW-1:0];
            n_div.quo_one = i_div.quo_one | (32'd1 << i_bit);
        end
        if ({32'b0, i_div.rem_two} >= dsh) begin
            n_div.rem_two = i_div.rem_two - dsh[NW-1:0];
            n_div.quo_two = i_div.quo_two | (32'd1 << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

`default_nettype wire

// ===== design/inverse_velocity_kinematics_unit.sv =====
// ---------------------------------------------------------------------------
// inverse_velocity_kinematics_unit
// SCARA inverse velocity kinematics: CORDIC sin/cos, Jacobian, adjugate
// inverse and saturating divide, as one stall-able pipeline.
// ---------------------------------------------------------------------------
//  channel  | signals                         | transaction
//  ---------+---------------------------------+---------------------------
//  input    | i_in_valid / o_in_ready         | velocities + two angles
//  output   | o_out_valid / i_out_ready       | three rates + singular
//  config   | i_cfg_we, i_cfg_index, i_cfg_data | link length write
//
//  One transaction per cycle while the output is not stalled; the path runs
//  through the CORDIC cell chain and the 32 cell restoring divider chain.
//  Every stage moves on one enable: the pipe advances unless the output
//  register holds a result that is not taken, so o_in_ready follows
//  i_out_ready combinationally. Reset clears all valid bits and loads both
//  link lengths with 13107 (0.2 m).
// ---------------------------------------------------------------------------
`default_nettype none

module inverse_velocity_kinematics_unit import ivk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_vel_x,
    input  wire logic signed [15:0] i_vel_y,
    input  wire logic signed [15:0] i_vel_z,
    input  wire logic signed [15:0] i_angle_one,
    input  wire logic signed [15:0] i_angle_two,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_rate_one,
    output logic signed [31:0]      o_rate_two,
    output logic signed [15:0]      o_rate_three,
    output logic                    o_singular
);

    // link length registers
    logic [15:0] r_link_one, r_link_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_one <= 16'd13107;
            r_link_two <= 16'd13107;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINK_ONE: r_link_one <= i_cfg_data;
                REG_LINK_TWO: r_link_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: output stage empty or being drained
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---- stage 0: angle reduction, CORDIC seed ----
    t_red red_one, red_sum;
    assign red_one = reduce(17'(i_angle_one));
    assign red_sum = reduce(17'(i_angle_one) + 17'(i_angle_two));

    logic  r0_valid;
    t_rot  r0_rot_a, r0_rot_b;
    t_side r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_rot_a         <= '{x: CORDIC_GAIN, y: '0, z: red_one.z};
            r0_rot_b         <= '{x: CORDIC_GAIN, y: '0, z: red_sum.z};
            r0_side.vx       <= i_vel_x;
            r0_side.vy       <= i_vel_y;
            r0_side.vz       <= i_vel_z;
            r0_side.neg_one  <= red_one.neg;
            r0_side.neg_sum  <= red_sum.neg;
        end
    end

    // ---- CORDIC cell chain ----
    logic  cv [0:CORDIC_STAGES];
    t_rot  ca [0:CORDIC_STAGES];
    t_rot  cb [0:CORDIC_STAGES];
    t_side cs [0:CORDIC_STAGES];

    assign cv[0] = r0_valid;
    assign ca[0] = r0_rot_a;
    assign cb[0] = r0_rot_b;
    assign cs[0] = r0_side;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ivk_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (5'(g)),
            .i_valid (cv[g]),
            .i_rot_a (ca[g]),
            .i_rot_b (cb[g]),
            .i_side  (cs[g]),
            .o_valid (cv[g+1]),
            .o_rot_a (ca[g+1]),
            .o_rot_b (cb[g+1]),
            .o_side  (cs[g+1])
        );
    end

    // ---- stage 1: round to Q2.14, apply half-turn sign ----
    t_rot  ea, eb;
    t_side es;
    assign ea = ca[CORDIC_STAGES];
    assign eb = cb[CORDIC_STAGES];
    assign es = cs[CORDIC_STAGES];

    logic signed [17:0] c1_rnd, s1_rnd, c12_rnd, s12_rnd;
    assign c1_rnd  = 18'((ea.x + 34'sd32768) >>> 16);
    assign s1_rnd  = 18'((ea.y + 34'sd32768) >>> 16);
    assign c12_rnd = 18'((eb.x + 34'sd32768) >>> 16);
    assign s12_rnd = 18'((eb.y + 34'sd32768) >>> 16);

    logic               r1_valid;
    logic signed [17:0] r1_s1, r1_c1, r1_s12, r1_c12;
    logic signed [15:0] r1_vx, r1_vy, r1_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c1  <= es.neg_one ? -c1_rnd  : c1_rnd;
            r1_s1  <= es.neg_one ? -s1_rnd  : s1_rnd;
            r1_c12 <= es.neg_sum ? -c12_rnd : c12_rnd;
            r1_s12 <= es.neg_sum ? -s12_rnd : s12_rnd;
            r1_vx  <= es.vx;
            r1_vy  <= es.vy;
            r1_vz  <= es.vz;
        end
    end

    // ---- stage 2: link length products rounded to Q.20 ----
    logic signed [16:0] l1_s, l2_s;
    assign l1_s = $signed({1'b0, r_link_one});
    assign l2_s = $signed({1'b0, r_link_two});

    logic signed [34:0] p_ta, p_tb, p_tc, p_te;
    assign p_ta = l1_s * r1_s1;
    assign p_tb = l2_s * r1_s12;
    assign p_tc = l1_s * r1_c1;
    assign p_te = l2_s * r1_c12;

    logic               r2_valid;
    logic signed [JW-1:0] r2_ta, r2_tb, r2_tc, r2_te;
    logic signed [15:0] r2_vx, r2_vy, r2_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ta <= JW'((p_ta + 35'sd512) >>> 10);
            r2_tb <= JW'((p_tb + 35'sd512) >>> 10);
            r2_tc <= JW'((p_tc + 35'sd512) >>> 10);
            r2_te <= JW'((p_te + 35'sd512) >>> 10);
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_vz <= r1_vz;
        end
    end

    // ---- stage 3: Jacobian terms ----
    logic               r3_valid;
    logic signed [JW-1:0] r3_a, r3_b, r3_d, r3_e;
    logic signed [15:0] r3_vx, r3_vy, r3_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_a  <= -r2_ta - r2_tb;
            r3_b  <= -r2_tb;
            r3_d  <= r2_tc + r2_te;
            r3_e  <= r2_te;
            r3_vx <= r2_vx;
            r3_vy <= r2_vy;
            r3_vz <= r2_vz;
        end
    end

    // ---- stage 4: products ----
    logic               r4_valid;
    logic signed [47:0] r4_bd, r4_ae;
    logic signed [39:0] r4_evx, r4_bvy, r4_dvx, r4_avy;
    logic signed [15:0] r4_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_bd  <= r3_b * r3_d;
            r4_ae  <= r3_a * r3_e;
            r4_evx <= r3_e * r3_vx;
            r4_bvy <= r3_b * r3_vy;
            r4_dvx <= r3_d * r3_vx;
            r4_avy <= r3_a * r3_vy;
            r4_vz  <= r3_vz;
        end
    end

    // ---- stage 5: determinant and numerators ----
    logic               r5_valid;
    logic signed [DW-1:0] r5_det;
    logic signed [40:0] r5_n1, r5_n2;
    logic signed [15:0] r5_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_det <= DW'(r4_bd) - DW'(r4_ae);
            r5_n1  <= 41'(r4_bvy) - 41'(r4_evx);
            r5_n2  <= 41'(r4_dvx) - 41'(r4_avy);
            r5_vz  <= r4_vz;
        end
    end

    // ---- stage 6: magnitudes, overflow check, divider seed ----
    logic [40:0]   n1_mag, n2_mag;
    logic [DW-1:0] det_mag;
    logic [NW-1:0] num1_mag, num2_mag;
    assign n1_mag   = r5_n1[40]  ? 41'(-r5_n1)  : 41'(r5_n1);
    assign n2_mag   = r5_n2[40]  ? 41'(-r5_n2)  : 41'(r5_n2);
    assign det_mag  = r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
    assign num1_mag = {n1_mag[39:0], 21'b0} >> 1;
    assign num2_mag = {n2_mag[39:0], 21'b0} >> 1;

    logic  r6_valid;
    t_div  r6_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_div.rem_one <= num1_mag;
            r6_div.rem_two <= num2_mag;
            r6_div.quo_one <= '0;
            r6_div.quo_two <= '0;
            r6_div.den     <= det_mag;
            r6_div.neg_one <= r5_n1[40] ^ r5_det[DW-1];
            r6_div.neg_two <= r5_n2[40] ^ r5_det[DW-1];
            // quotient of 2^32 or more saturates
            r6_div.ovf_one <= {20'b0, num1_mag} >= {det_mag, 32'b0};
            r6_div.ovf_two <= {20'b0, num2_mag} >= {det_mag, 32'b0};
            r6_div.sing    <= (r5_det == '0);
            r6_div.r3      <= (r5_vz == -16'sd32768) ? 16'sd32767 : -r5_vz;
        end
    end

    // ---- restoring divider cell chain, MSB first ----
    logic dv [0:DIV_STEPS];
    t_div dd [0:DIV_STEPS];

    assign dv[0] = r6_valid;
    assign dd[0] = r6_div;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        ivk_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (5'(DIV_STEPS - 1 - g)),
            .i_valid (dv[g]),
            .i_div   (dd[g]),
            .o_valid (dv[g+1]),
            .o_div   (dd[g+1])
        );
    end

    // ---- output stage: sign, saturation, singular ----
    t_div fd;
    assign fd = dd[DIV_STEPS];

    function automatic logic [31:0] sat_rate(input logic [31:0] q, input logic neg,
                                             input logic ovf);
        logic [31:0] v;
        if (neg) begin
            v = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : -q;
        end else begin
            v = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
        end
        return v;
    endfunction

    logic signed [31:0] r_rate_one, r_rate_two;
    logic signed [15:0] r_rate_three;
    logic               r_singular, r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_singular   <= fd.sing;
            r_rate_one   <= fd.sing ? '0 : sat_rate(fd.quo_one, fd.neg_one, fd.ovf_one);
            r_rate_two   <= fd.sing ? '0 : sat_rate(fd.quo_two, fd.neg_two, fd.ovf_two);
            r_rate_three <= fd.sing ? '0 : fd.r3;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rate_one   = r_rate_one;
    assign o_rate_two   = r_rate_two;
    assign o_rate_three = r_rate_three;
    assign o_singular   = r_singular;

endmodule

`default_nettype wire

// ===== design/ivk_checker.sv =====
// ---------------------------------------------------------------------------
// ivk_checker
// Port-level checks for the inverse velocity kinematics unit.
// ---------------------------------------------------------------------------
`default_nettype none

module ivk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_rate_one,
    input wire logic [31:0] o_rate_two,
    input wire logic [15:0] o_rate_three,
    input wire logic        o_singular
);

    // pending result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // pipe stalls exactly when the output is blocked
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // singular results carry zero rates
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |->
        (o_rate_one == 32'd0 && o_rate_two == 32'd0 && o_rate_three == 16'd0))
        else $error("singular result with nonzero rate");

endmodule

bind inverse_velocity_kinematics_unit ivk_checker u_ivk_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_rate_one   (o_rate_one),
    .o_rate_two   (o_rate_two),
    .o_rate_three (o_rate_three),
    .o_singular   (o_singular)
);

`default_nettype wire

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the SCARA inverse velocity kinematics unit. A local
// fixed-point predictor (CORDIC sin/cos, Jacobian, adjugate divide) computes
// the expected joint rates per accepted transaction; a checker compares every
// output transaction in order. Link lengths are swept across extremes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import ivk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] rate_one;
        logic signed [31:0] rate_two;
        logic signed [15:0] rate_three;
        logic               singular;
    } t_rates;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_vel_x, i_vel_y, i_vel_z, i_angle_one, i_angle_two;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_rate_one, o_rate_two;
    logic signed [15:0] o_rate_three;
    logic               o_singular;

    inverse_velocity_kinematics_unit dut (.*);

    // atan(2^-i) scaled by 2^30
    localparam longint ATAN_LUT [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };
    localparam int DRAIN_CYCLES = CORDIC_STAGES + 48;

    t_rates      rate_queue[$];
    logic [15:0] link_one_len, link_two_len;
    int          snd_idle_pct, rcv_idle_pct;
    int          err_count, sent_count, checked_count, sing_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Q2.13 angle -> Q2.14 sin/cos
    function automatic void joint_sin_cos(input int ang, output longint s,
                                          output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        while (ang > 25736) ang -= 51472;
        while (ang < -25736) ang += 51472;
        if (ang > 12868) begin
            ang -= 25736;
            flip = 1'b1;
        end else if (ang < -12868) begin
            ang += 25736;
            flip = 1'b1;
        end
        z = longint'(ang) * 131072;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_LUT[i];
            end else begin
                x += dx; y -= dy; z += ATAN_LUT[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_rates predict_rates(input logic signed [15:0] vx,
            input logic signed [15:0] vy, input logic signed [15:0] vz,
            input logic signed [15:0] q1, input logic signed [15:0] q2);
        longint s1, c1, s12, c12, ta, tb2, tc, te, a, b, d, e, det, n1, n2, l1, l2;
        t_rates r;
        l1 = longint'(link_one_len);
        l2 = longint'(link_two_len);
        joint_sin_cos(int'(q1), s1, c1);
        joint_sin_cos(int'(q1) + int'(q2), s12, c12);
        ta  = (l1 * s1 + 512) >>> 10;
        tb2 = (l2 * s12 + 512) >>> 10;
        tc  = (l1 * c1 + 512) >>> 10;
        te  = (l2 * c12 + 512) >>> 10;
        a = -ta - tb2;
        b = -tb2;
        d = tc + te;
        e = te;
        det = b * d - a * e;
        r = '{0, 0, 0, 1'b0};
        if (det == 0) begin
            r.singular = 1'b1;
        end else begin
            n1 = -e * longint'(vx) + b * longint'(vy);
            n2 = d * longint'(vx) - a * longint'(vy);
            r.rate_one = 32'(clamp32((n1 * 1048576) / det));
            r.rate_two = 32'(clamp32((n2 * 1048576) / det));
            // negating the most negative velocity saturates
            r.rate_three = (vz == -16'sd32768) ? 16'sd32767 : -vz;
        end
        return r;
    endfunction

    // one input transaction; valid is left high after acceptance
    task automatic send_item(input logic signed [15:0] vx, vy, vz, q1, q2);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_vel_x     <= vx;
        i_vel_y     <= vy;
        i_vel_z     <= vz;
        i_angle_one <= q1;
        i_angle_two <= q2;
        do @(posedge i_clk); while (!o_in_ready);
        rate_queue.push_back(predict_rates(vx, vy, vz, q1, q2));
        sent_count++;
    endtask

    // drain, then settle before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (rate_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_links(input logic [15:0] len_one, len_two);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LINK_ONE;
        i_cfg_data  <= len_one;
        @(posedge i_clk);
        i_cfg_index <= REG_LINK_TWO;
        i_cfg_data  <= len_two;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        link_one_len = len_one;
        link_two_len = len_two;
    endtask

    function automatic logic signed [15:0] rand_angle();
        // mostly within +-pi, sometimes any pattern
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'(signed'($urandom_range(51472)) - 25736);
    endfunction

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(16'($urandom), 16'($urandom), 16'($urandom),
                      rand_angle(), rand_angle());
        end
    endtask

    // reset lengths: field extremes, wrap-around angles, singular pose
    task automatic test_directed();
        send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(16'sd32767, 16'sd32767, 16'sd32767, 16'sd25736, 16'sd25736);
        send_item(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd25736, -16'sd25736);
        send_item(16'sd4096, -16'sd4096, 16'sd100, 16'sd12868, 16'sd12868);
        send_item(-16'sd4096, 16'sd4096, -16'sd100, -16'sd12868, 16'sd12869);
        send_item(16'sd1000, 16'sd2000, 16'sd3000, 16'sd5000, 16'sd0);
        send_item(16'sd1000, 16'sd2000, 16'sd3000, 16'sd5000, 16'sd25736);
        send_item(16'sd32767, -16'sd32768, 16'sd1, 16'sd32767, 16'sd32767);
        send_item(-16'sd32768, 16'sd32767, -16'sd1, -16'sd32768, -16'sd32768);
        send_item(16'sd123, 16'sd456, -16'sd32768, 16'sd32767, -16'sd32768);
        send_item(16'sd8192, 16'sd8192, 16'sd0, 16'sd6434, 16'sd6434);
        send_item(16'sd8192, -16'sd8192, 16'sd0, -16'sd19302, 16'sd12868);
        send_item(-16'sd1, 16'sd1, 16'sd2, 16'sd25735, 16'sd1);
        send_item(16'sd1, 16'sd0, 16'sd0, 16'sd12867, -16'sd1);
        wait_idle();
    endtask

    // zero and full-scale links; a zero link forces a singular Jacobian
    task automatic test_link_extremes();
        write_links(16'd0, 16'($urandom));
        random_items(40);
        wait_idle();
        write_links(16'($urandom), 16'd0);
        random_items(40);
        wait_idle();
        write_links(16'hFFFF, 16'hFFFF);
        send_item(16'sd32767, -16'sd32768, 16'sd5, 16'sd25736, -16'sd25736);
        send_item(-16'sd32768, 16'sd32767, 16'sd5, 16'sd100, 16'sd3);
        random_items(100);
        wait_idle();
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                     input int count);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        write_links(16'($urandom), 16'($urandom));
        random_items(count / 2);
        wait_idle();
        write_links(16'($urandom_range(65535, 1)), 16'($urandom_range(4000)));
        random_items(count / 2);
        wait_idle();
    endtask

    // receiver side: random backpressure and in-order result check
    always @(posedge i_clk) begin
        t_rates exp_r;
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rate_queue.size() == 0) begin
                $display("%t: unexpected result, expected none, got %0d %0d %0d %b",
                         $realtime, o_rate_one, o_rate_two, o_rate_three, o_singular);
                err_count++;
            end else begin
                exp_r = rate_queue.pop_front();
                checked_count++;
                if (exp_r.singular) sing_count++;
                if (o_rate_one !== exp_r.rate_one) begin
                    $display("%t: rate_one expected %0d got %0d", $realtime,
                             exp_r.rate_one, o_rate_one);
                    err_count++;
                end
                if (o_rate_two !== exp_r.rate_two) begin
                    $display("%t: rate_two expected %0d got %0d", $realtime,
                             exp_r.rate_two, o_rate_two);
                    err_count++;
                end
                if (o_rate_three !== exp_r.rate_three) begin
                    $display("%t: rate_three expected %0d got %0d", $realtime,
                             exp_r.rate_three, o_rate_three);
                    err_count++;
                end
                if (o_singular !== exp_r.singular) begin
                    $display("%t: singular expected %b got %b", $realtime,
                             exp_r.singular, o_singular);
                    err_count++;
                end
            end
        end
    end

    initial begin
        err_count = 0; sent_count = 0; checked_count = 0; sing_count = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        link_one_len = 16'd13107;
        link_two_len = 16'd13107;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_LINK_ONE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        {i_vel_x, i_vel_y, i_vel_z, i_angle_one, i_angle_two} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_link_extremes();
        test_random_phase(16, 51, 600);
        test_random_phase(51, 16, 600);
        test_random_phase(0, 0, 600);

        $display("covered %0d transactions (%0d singular) over several link settings",
                 sent_count, sing_count);
        $display("checked %0d results, %0d mismatches", checked_count, err_count);
        if (err_count == 0 && checked_count == sent_count) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/ivk_pkg.sv
design/ivk_cordic_cell.sv
design/ivk_div_cell.sv
design/inverse_velocity_kinematics_unit.sv
design/ivk_checker.sv
test/tb.sv
